// ----- rtl/core/slcd_pkg.sv -----
`timescale 1ns / 1ps

package slcd_pkg;

    // framing constants
    localparam logic [7:0] SYNC_FIRST       = 8'h44;
    localparam logic [7:0] SYNC_SECOND      = 8'h4B;
    localparam logic [7:0] SYNC_SUM         = SYNC_FIRST + SYNC_SECOND;
    localparam int         HDR_STORE_DEPTH  = 8;
    localparam int         HDR_IDX_W        = $clog2(HDR_STORE_DEPTH);
    localparam logic [15:0] MIN_PACKET_BYTES = 16'd11;
    localparam int         LEN_OUT_W        = 11;

    // default length limit handed to the top level
    localparam int         MAX_PACKET_BYTES_DEF = 1024;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    typedef struct packed {
        logic                 is_packet_end;
        logic [7:0]           payload_byte;
        logic [LEN_OUT_W-1:0] packet_length;
        logic [7:0]           dest_address;
        logic [7:0]           source_address;
        logic [7:0]           message_number;
        logic [7:0]           reference_number;
        logic [15:0]          packet_type;
        logic                 checksum_ok;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } result_xfer_t;

endpackage

// ----- rtl/core/slcd_if.sv -----
`timescale 1ns / 1ps

interface slcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcd_out_if import slcd_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 is_packet_end;
    logic [7:0]           payload_byte;
    logic [LEN_OUT_W-1:0] packet_length;
    logic [7:0]           dest_address;
    logic [7:0]           source_address;
    logic [7:0]           message_number;
    logic [7:0]           reference_number;
    logic [15:0]          packet_type;
    logic                 checksum_ok;

    modport source (
        output valid, output is_packet_end, output payload_byte, output packet_length,
        output dest_address, output source_address, output message_number,
        output reference_number, output packet_type, output checksum_ok,
        input ready
    );
    modport sink (
        input valid, input is_packet_end, input payload_byte, input packet_length,
        input dest_address, input source_address, input message_number,
        input reference_number, input packet_type, input checksum_ok,
        output ready
    );
endinterface

// ----- rtl/core/sync_length_checksum_deframer.sv -----
`timescale 1ns / 1ps

// Deframer for length-prefixed packets on a byte stream. Each input transaction
// carries one received byte. The block hunts for the sync pair 0x44 0x4B (a
// wrong second byte restarts the hunt and is not itself retried as a first sync
// byte), then captures eight header bytes: little-endian 16-bit total length,
// destination, source, message number, reference number and little-endian
// 16-bit packet type. A length below 11 or above MAX_PACKET_BYTES drops the
// frame silently. Every payload byte gives one output transaction with
// is_packet_end low; the trailing checksum byte gives one transaction with
// is_packet_end high and checksum_ok set when the 8-bit sum of all bytes from
// the first sync byte up to the last payload byte matches it. Header fields are
// repeated on every output transaction. One byte is accepted per clock while
// input ready is high: the parser updates its state in the cycle of acceptance
// and the result lands in a single output register, so throughput is one byte
// per cycle when the sink does not stall, and input ready drops only while an
// output transaction is held and the sink is not ready.

module sync_length_checksum_deframer import slcd_pkg::*; #(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    slcd_in_if.sink    in_ch,
    slcd_out_if.source out_ch
);

    logic         in_ready;
    logic         accept;
    logic         out_valid;
    result_t      out_data;
    result_xfer_t res;

    // byte transaction accepted this cycle
    assign accept      = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    slcd_parser #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (in_ch.rx_byte),
        .res     (res)
    );

    slcd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .out_ready (out_ch.ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // output transaction fields
    assign out_ch.valid            = out_valid;
    assign out_ch.is_packet_end    = out_data.is_packet_end;
    assign out_ch.payload_byte     = out_data.payload_byte;
    assign out_ch.packet_length    = out_data.packet_length;
    assign out_ch.dest_address     = out_data.dest_address;
    assign out_ch.source_address   = out_data.source_address;
    assign out_ch.message_number   = out_data.message_number;
    assign out_ch.reference_number = out_data.reference_number;
    assign out_ch.packet_type      = out_data.packet_type;
    assign out_ch.checksum_ok      = out_data.checksum_ok;

endmodule

// ----- rtl/core/slcd_parser.sv -----
`timescale 1ns / 1ps

module slcd_parser import slcd_pkg::*; #(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic [7:0]   rx_byte,
    output result_xfer_t res
);

    // payload bytes left fits len - 11, at most MAX_PACKET_BYTES - 11
    localparam int PAY_W = (MAX_PACKET_BYTES - 10 > 1) ? $clog2(MAX_PACKET_BYTES - 10) : 1;
    localparam logic [15:0] MAX_LEN = 16'(MAX_PACKET_BYTES);

    phase_t               phase_reg, phase_next;
    logic [HDR_IDX_W-1:0] idx_reg, idx_next;
    logic [PAY_W-1:0]     left_reg, left_next;
    logic [7:0]           sum_reg, sum_next;
    logic [7:0]           hdr_reg [HDR_STORE_DEPTH];

    logic [15:0]          hdr_len;
    logic                 hdr_last;
    logic                 len_bad;
    logic [15:0]          pay_len;

    assign hdr_len  = {hdr_reg[1], hdr_reg[0]};
    assign hdr_last = (idx_reg == HDR_IDX_W'(HDR_STORE_DEPTH - 1));
    assign len_bad  = (hdr_len < MIN_PACKET_BYTES) || (hdr_len > MAX_LEN);
    assign pay_len  = hdr_len - MIN_PACKET_BYTES;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT1:
            begin
                if (rx_byte == SYNC_FIRST)
                    phase_next = PH_HUNT2;
            end
            PH_HUNT2:
            begin
                phase_next = (rx_byte == SYNC_SECOND) ? PH_HEADER : PH_HUNT1;
            end
            PH_HEADER:
            begin
                if (hdr_last)
                begin
                    if (len_bad)
                        phase_next = PH_HUNT1;
                    else if (hdr_len == MIN_PACKET_BYTES)
                        phase_next = PH_CHECK;
                    else
                        phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (left_reg == PAY_W'(1))
                    phase_next = PH_CHECK;
            end
            PH_CHECK:
            begin
                phase_next = PH_HUNT1;
            end
            default:
            begin
                phase_next = PH_HUNT1;
            end
        endcase
    end

    // counters and running sum
    always_comb
    begin
        idx_next  = idx_reg;
        left_next = left_reg;
        sum_next  = sum_reg;
        case (phase_reg)
            PH_HUNT2:
            begin
                idx_next = '0;
                sum_next = SYNC_SUM;
            end
            PH_HEADER:
            begin
                idx_next = idx_reg + HDR_IDX_W'(1);
                sum_next = sum_reg + rx_byte;
                if (hdr_last)
                    left_next = pay_len[PAY_W-1:0];
            end
            PH_PAYLOAD:
            begin
                sum_next  = sum_reg + rx_byte;
                left_next = left_reg - PAY_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // result outputs
    always_comb
    begin
        res.valid                 = 1'b0;
        res.data.is_packet_end    = 1'b0;
        res.data.payload_byte     = 8'd0;
        res.data.checksum_ok      = 1'b0;
        res.data.packet_length    = hdr_len[LEN_OUT_W-1:0];
        res.data.dest_address     = hdr_reg[2];
        res.data.source_address   = hdr_reg[3];
        res.data.message_number   = hdr_reg[4];
        res.data.reference_number = hdr_reg[5];
        res.data.packet_type      = {hdr_reg[7], hdr_reg[6]};
        unique case (phase_reg)
            PH_PAYLOAD:
            begin
                res.valid             = accept;
                res.data.payload_byte = rx_byte;
            end
            PH_CHECK:
            begin
                res.valid              = accept;
                res.data.is_packet_end = 1'b1;
                res.data.checksum_ok   = (sum_reg == rx_byte);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT1;
            idx_reg   <= '0;
            left_reg  <= '0;
            sum_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
        end
    end

    // header store, written once per header byte
    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PH_HEADER)
            hdr_reg[idx_reg] <= rx_byte;
    end

endmodule

// ----- rtl/core/slcd_out_reg.sv -----
`timescale 1ns / 1ps

module slcd_out_reg import slcd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  result_xfer_t res,
    input  logic         out_ready,
    output logic         in_ready,
    output logic         out_valid,
    output result_t      out_data
);

    logic    valid_reg;
    result_t data_reg;

    // take a new byte whenever the held result is empty or leaving
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && res.valid)
            data_reg <= res.data;
    end

endmodule
